[rtl/ahss_pkg.sv]
// Shared types and constants for the adaptive hopping slot scheduler.
// Used by ahss_div and adaptive_hopping_slot_scheduler; no dependencies.
`default_nettype none

package ahss_pkg;

  // Datapath width of the shared divider
  localparam int unsigned DIV_W = 16;

  // Parameter defaults
  localparam int unsigned MAX_PHASE_DEF    = 7;
  localparam int unsigned NEWTON_STEPS_DEF = 5;

  // Command codes carried in the request's tuser
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHAN_COUNT = 2'd0;
  localparam logic [1:0] CFG_TARGET     = 2'd1;

  // Register reset values
  localparam logic [4:0] CHAN_COUNT_RST = 5'd16;
  localparam logic [7:0] TARGET_RST     = 8'd10;

  // Scheduler state reset values
  localparam logic [15:0] PHASE_END_RST = 16'd3;
  localparam logic [7:0]  CLIQUE_RST    = 8'd2;

  // Channel mapping and arithmetic constants
  localparam logic [4:0]  CHAN_BASE  = 5'd11;
  localparam logic [4:0]  CHAN_IDLE  = 5'd26;
  localparam logic [4:0]  K_MAX      = 5'd16;
  localparam logic [15:0] ROOT_SEED  = 16'd100;
  localparam logic [15:0] PROB_FULL  = 16'hFFFF;

endpackage

`default_nettype wire

[rtl/ahss_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle, shared by the scheduler.
// Depends on ahss_pkg for the datapath width.
`default_nettype none

module ahss_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ahss_pkg::DIV_W-1:0] dividend,
  input  wire logic [ahss_pkg::DIV_W-1:0] divisor,
  output logic                           done,
  output logic [ahss_pkg::DIV_W-1:0]     quotient,
  output logic [ahss_pkg::DIV_W-1:0]     remainder
);

  localparam int unsigned W     = ahss_pkg::DIV_W;
  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [W:0] rem_sh;
  logic       fits;

  // Shift in the next dividend bit and try the subtraction
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
        cnt_r <= CNT_W'(W);
      end else if (cnt_r != '0) begin
        // The partial remainder stays below the divisor, so W bits hold it
        rem_r  <= fits ? W'(rem_sh - {1'b0, dvs_r}) : rem_sh[W-1:0];
        quo_r  <= {quo_r[W-2:0], fits};
        cnt_r  <= cnt_r - CNT_W'(1);
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[rtl/adaptive_hopping_slot_scheduler.sv]
// Slot scheduler for multichannel neighbor discovery (top level).
// Depends on ahss_pkg and ahss_div.
`default_nettype none

// Channel | Dir | Handshake                | Contents
// --------+-----+--------------------------+----------------------------------------
// in_     | in  | in_tvalid / in_tready    | command in tuser, slot inputs in tdata
// out_    | out | out_tvalid / out_tready  | slot kind in tuser, slot decision tdata
// cfg_    | in  | cfg_valid / cfg_ready    | register index and write data
//
// Start, stop, the unused op and ticks that end discovery: the request goes straight
// to ST_OUT, which moves the result into the output register once that is free.
// A discovery tick runs one shared divider for the phase boundary modulo, up to
// NEWTON_STEPS square-root steps and the probability scale; the boundary check
// is skipped on a slot count wrap to zero or a zero phase end. The divider and
// the 16-bit multiplier are the units that set how long a tick takes.
// Reset is synchronous, active low. in_tready is low while a request is in work;
// a finished result that finds the output register still occupied holds the
// sequencer, and with it in_tready, until out_tready frees that register.

module adaptive_hopping_slot_scheduler #(
  parameter int unsigned MAX_PHASE    = ahss_pkg::MAX_PHASE_DEF,
  parameter int unsigned NEWTON_STEPS = ahss_pkg::NEWTON_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [7:0] neighbors_found, [23:8] coin_random,
                                       // [27:24] channel_pick, [31:28] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [0] transmit, [5:1] radio_channel,
                                       // [21:6] tx_probability, [37:22] slot_number,
                                       // [40:38] phase_number, [47:41] zero
  output logic [0:0]       out_tuser,  // [0] slot_active
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int unsigned W      = ahss_pkg::DIV_W;
  localparam int unsigned STEP_W = $clog2(NEWTON_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_MODW, ST_SQ, ST_SQM, ST_SS, ST_NT, ST_NTW,
    ST_Q, ST_QW, ST_PM, ST_FIN, ST_OUT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [4:0] chan_count_r;
  logic [7:0] target_r;

  // Scheduler state
  logic        running_r;
  logic [15:0] slot_count_r;
  logic [2:0]  phase_r;
  logic [15:0] phase_end_r;
  logic [7:0]  clique_r;

  // Latched request and working registers
  logic [15:0]       coin_r;
  logic [3:0]        pick_r;
  logic [4:0]        k_r;
  logic [15:0]       a_r;
  logic [15:0]       s_r;
  logic [15:0]       x_r;
  logic [15:0]       prev_r;
  logic [STEP_W-1:0] step_r;
  logic [15:0]       mul_r;

  // Result under construction and output register
  logic        res_active_r;
  logic        res_tx_r;
  logic [4:0]  res_chan_r;
  logic [15:0] res_prob_r;
  logic        out_valid_r;
  logic        out_active_r;
  logic        out_tx_r;
  logic [4:0]  out_chan_r;
  logic [15:0] out_prob_r;
  logic [15:0] out_slot_r;
  logic [2:0]  out_phase_r;

  // Request fields
  ahss_pkg::op_t in_op;
  logic [7:0]    in_found;
  logic [15:0]   in_coin;
  logic [3:0]    in_pick;
  logic          in_fire;
  logic          out_free;

  // Combinational helpers
  logic [4:0]  k_clamp;
  logic [15:0] slot_nxt;
  logic [2:0]  phase_nxt;
  logic [7:0]  clique_nxt;
  logic [10:0] pe_prod;
  logic [15:0] four_kn;
  logic [15:0] x_nxt;
  logic [3:0]  pick_lim;
  logic [3:0]  pick_clamp;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [15:0] mul_lo;

  // Shared divider
  logic         div_start;
  logic [W-1:0] div_dvd;
  logic [W-1:0] div_dvs;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;

  assign in_op    = ahss_pkg::op_t'(in_tuser);
  assign in_found = in_tdata[7:0];
  assign in_coin  = in_tdata[23:8];
  assign in_pick  = in_tdata[27:24];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Clamp channel count to 1..16
  always_comb begin
    if (chan_count_r == 5'd0) begin
      k_clamp = 5'd1;
    end else if (chan_count_r > ahss_pkg::K_MAX) begin
      k_clamp = ahss_pkg::K_MAX;
    end else begin
      k_clamp = chan_count_r;
    end
  end

  assign slot_nxt = slot_count_r + 16'd1;

  // Phase boundary update: saturate phase, set estimate to 2**phase, push phase end out
  assign phase_nxt  = (phase_r < 3'(MAX_PHASE)) ? phase_r + 3'd1 : phase_r;
  assign clique_nxt = 8'd1 << phase_nxt;
  assign pe_prod    = 11'(phase_nxt) * 11'(clique_nxt);

  assign four_kn = 16'({k_r, 2'b00}) * 16'(clique_r);

  // Newton step: x = (x + s/x) / 2 over a 17-bit sum
  assign x_nxt = 16'(({1'b0, x_r} + {1'b0, div_quo}) >> 1);

  assign pick_lim   = 4'(k_r - 5'd1);
  assign pick_clamp = (pick_r > pick_lim) ? pick_lim : pick_r;

  // Shared multiplier: a*a for the discriminant, then (a - x) * scale
  assign mul_a  = (state_r == ST_SQM) ? a_r : (a_r - x_r);
  assign mul_b  = (state_r == ST_SQM) ? a_r : div_quo;
  assign mul_lo = 16'(mul_a * mul_b);

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_dvd   = s_r;
    div_dvs   = x_r;
    case (state_r)
      ST_MOD: begin
        div_start = 1'b1;
        div_dvd   = slot_count_r;
        div_dvs   = phase_end_r;
      end
      ST_NT: begin
        div_start = (x_r != 16'd0);
      end
      ST_Q: begin
        div_start = 1'b1;
        div_dvd   = ahss_pkg::PROB_FULL;
        div_dvs   = {7'd0, clique_r, 1'b0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ahss_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chan_count_r <= ahss_pkg::CHAN_COUNT_RST;
      target_r     <= ahss_pkg::TARGET_RST;
      running_r    <= 1'b0;
      slot_count_r <= 16'd0;
      phase_r      <= 3'd0;
      phase_end_r  <= ahss_pkg::PHASE_END_RST;
      clique_r     <= ahss_pkg::CLIQUE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      // Register writes; a request in work keeps the channel count latched when taken
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ahss_pkg::CFG_CHAN_COUNT: chan_count_r <= cfg_data[4:0];
          ahss_pkg::CFG_TARGET:     target_r     <= cfg_data;
          default: ;
        endcase
      end

      // Drop the result once taken; a reload from ST_OUT wins below
      if (out_valid_r && out_tready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            coin_r       <= in_coin;
            pick_r       <= in_pick;
            k_r          <= k_clamp;
            res_active_r <= 1'b0;
            res_tx_r     <= 1'b0;
            res_chan_r   <= ahss_pkg::CHAN_IDLE;
            res_prob_r   <= 16'd0;
            state_r      <= ST_OUT;
            case (in_op)
              ahss_pkg::OP_TICK: begin
                if (running_r && (in_found < target_r)) begin
                  slot_count_r <= slot_nxt;
                  // Skip the boundary check on wrap to zero or a zero phase end
                  state_r <= ((slot_nxt != 16'd0) && (phase_end_r != 16'd0)) ?
                             ST_MOD : ST_SQ;
                end else begin
                  // Discovery over: drop back to the idle schedule
                  running_r    <= 1'b0;
                  slot_count_r <= 16'd0;
                  phase_r      <= 3'd0;
                  phase_end_r  <= ahss_pkg::PHASE_END_RST;
                  clique_r     <= ahss_pkg::CLIQUE_RST;
                end
              end
              ahss_pkg::OP_START: running_r <= 1'b1;
              ahss_pkg::OP_STOP:  running_r <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_MOD: begin
          state_r <= ST_MODW;
        end
        ST_MODW: begin
          if (div_done) begin
            if (div_rem == 16'd0) begin
              phase_r     <= phase_nxt;
              clique_r    <= clique_nxt;
              phase_end_r <= phase_end_r + 16'({pe_prod, 2'b00});
            end
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          // a = 2k + n - 1
          a_r     <= 16'({k_r, 1'b0}) + 16'(clique_r) - 16'd1;
          state_r <= ST_SQM;
        end
        ST_SQM: begin
          mul_r   <= mul_lo;
          state_r <= ST_SS;
        end
        ST_SS: begin
          s_r     <= mul_r - four_kn;
          x_r     <= ahss_pkg::ROOT_SEED;
          prev_r  <= 16'd0;
          step_r  <= '0;
          state_r <= ST_NT;
        end
        ST_NT: begin
          // A zero root ends the iteration
          state_r <= (x_r == 16'd0) ? ST_Q : ST_NTW;
        end
        ST_NTW: begin
          if (div_done) begin
            x_r    <= x_nxt;
            prev_r <= x_nxt;
            if (((step_r != '0) && (prev_r == x_nxt)) ||
                (step_r == STEP_W'(NEWTON_STEPS - 1))) begin
              state_r <= ST_Q;
            end else begin
              step_r  <= step_r + STEP_W'(1);
              state_r <= ST_NT;
            end
          end
        end
        ST_Q: begin
          state_r <= ST_QW;
        end
        ST_QW: begin
          if (div_done) begin
            state_r <= ST_PM;
          end
        end
        ST_PM: begin
          mul_r   <= mul_lo;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          res_active_r <= 1'b1;
          res_tx_r     <= (coin_r < mul_r);
          res_chan_r   <= ahss_pkg::CHAN_BASE + {1'b0, pick_clamp};
          res_prob_r   <= mul_r;
          state_r      <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the output register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_active_r <= res_active_r;
            out_tx_r     <= res_tx_r;
            out_chan_r   <= res_chan_r;
            out_prob_r   <= res_prob_r;
            out_slot_r   <= slot_count_r;
            out_phase_r  <= phase_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_active_r;
  assign out_tdata  = {7'd0, out_phase_r, out_slot_r, out_prob_r, out_chan_r, out_tx_r};

  // The divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_MODW || state_r == ST_NTW || state_r == ST_QW))
    else $error("divider finished outside a wait state");

  // The clique estimate stays a power of two
  a_clique_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(clique_r))
    else $error("clique estimate is not a power of two");

  // The phase never passes its saturation point
  a_phase_sat: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= 3'(MAX_PHASE))
    else $error("phase beyond saturation");

  // A newly accepted request leaves the block busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request accepted while the previous one is still in work");

endmodule

`default_nettype wire

[test/adaptive_hopping_slot_scheduler_tb.sv]
// Self-checking testbench for adaptive_hopping_slot_scheduler: directed and random
// slot requests under varied pacing, checked against an in-bench slot planner.
// Depends on ahss_pkg and the scheduler RTL.
`timescale 1ns / 1ps

typedef struct {
  logic        slot_active;
  logic        transmit;
  logic [4:0]  channel;
  logic [15:0] prob;
  logic [15:0] slot;
  logic [2:0]  phase;
} slot_decision_t;

// Tracks scheduler state, plans the decision for each accepted request and
// compares the block's results in order.
class slot_plan_board;
  logic [4:0]     chan_count;
  logic [7:0]     target;
  bit             running;
  logic [15:0]    slot_count;
  logic [2:0]     phase;
  logic [15:0]    phase_end;
  logic [7:0]     clique;
  slot_decision_t due[$];
  int             mismatches;
  int             requests;
  int             slots;
  int             transmits;
  int             idle_resets;
  int             reg_writes;
  int             top_phase;

  function new();
    chan_count  = ahss_pkg::CHAN_COUNT_RST;
    target      = ahss_pkg::TARGET_RST;
    mismatches  = 0;
    requests    = 0;
    slots       = 0;
    transmits   = 0;
    idle_resets = 0;
    reg_writes  = 0;
    top_phase   = 0;
    back_to_idle();
  endfunction

  function void back_to_idle();
    running    = 1'b0;
    slot_count = '0;
    phase      = '0;
    phase_end  = ahss_pkg::PHASE_END_RST;
    clique     = ahss_pkg::CLIQUE_RST;
  endfunction

  function int pending();
    return due.size();
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] val);
    reg_writes++;
    if (idx == ahss_pkg::CFG_CHAN_COUNT) chan_count = val[4:0];
    else if (idx == ahss_pkg::CFG_TARGET) target = val;
  endfunction

  // p = (a - sqrt(a*a - 4kn)) * (65535 / 2n), all in 16-bit wrap
  function logic [15:0] tx_prob_for(int unsigned k, int unsigned n);
    logic [15:0] a;
    logic [15:0] s;
    logic [15:0] root;
    logic [15:0] prior;
    logic [15:0] gap;
    int unsigned steps;
    bit          settled;
    a       = 16'(2 * k + n - 1);
    s       = 16'(32'(a) * 32'(a) - 4 * k * n);
    root    = ahss_pkg::ROOT_SEED;
    prior   = '0;
    steps   = 0;
    settled = 1'b0;
    while (!settled && steps < ahss_pkg::NEWTON_STEPS_DEF) begin
      if (root == 0) begin
        settled = 1'b1;
      end else begin
        root = 16'((32'(root) + 32'(s) / 32'(root)) / 32'd2);
        if (steps > 0 && prior == root) settled = 1'b1;
        prior = root;
        steps++;
      end
    end
    gap = a - root;
    return 16'(32'(gap) * (32'hFFFF / (2 * n)));
  endfunction

  function void note_request(ahss_pkg::op_t op, logic [7:0] found, logic [15:0] coin,
                             logic [3:0] pick);
    slot_decision_t d;
    int unsigned    k;
    int unsigned    lane;
    d.slot_active = 1'b0;
    d.transmit    = 1'b0;
    d.channel     = ahss_pkg::CHAN_IDLE;
    d.prob        = '0;
    requests++;
    case (op)
      ahss_pkg::OP_TICK: begin
        if (running && found < target) begin
          k = chan_count;
          if (k < 1) k = 1;
          if (k > ahss_pkg::K_MAX) k = ahss_pkg::K_MAX;
          slot_count = slot_count + 16'd1;
          if (slot_count != 0 && phase_end != 0 && slot_count % phase_end == 0) begin
            if (phase < ahss_pkg::MAX_PHASE_DEF) phase = phase + 3'd1;
            clique    = 8'(1 << phase);
            phase_end = 16'(32'(phase_end) + 32'd4 * 32'(phase) * 32'(clique));
          end
          d.prob = tx_prob_for(k, clique);
          lane   = pick;
          if (lane > k - 1) lane = k - 1;
          d.slot_active = 1'b1;
          d.transmit    = (coin < d.prob);
          d.channel     = 5'(ahss_pkg::CHAN_BASE + lane);
          slots++;
          if (d.transmit) transmits++;
          if (phase > top_phase) top_phase = phase;
        end else begin
          back_to_idle();
          idle_resets++;
        end
      end
      ahss_pkg::OP_START: running = 1'b1;
      ahss_pkg::OP_STOP:  running = 1'b0;
      default: ;
    endcase
    d.slot  = slot_count;
    d.phase = phase;
    due.push_back(d);
  endfunction

  function void match_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 20)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_decision(logic [0:0] kind, logic [47:0] word);
    slot_decision_t d;
    if (due.size() == 0) begin
      mismatches++;
      if (mismatches <= 20)
        $display("%0t: result with no request pending, expected none, actual tdata %h tuser %h",
                 $time, word, kind);
      return;
    end
    d = due.pop_front();
    match_field("slot_active", 16'(d.slot_active), 16'(kind[0]));
    match_field("transmit", 16'(d.transmit), 16'(word[0]));
    match_field("radio_channel", 16'(d.channel), 16'(word[5:1]));
    match_field("tx_probability", d.prob, word[21:6]);
    match_field("slot_number", d.slot, word[37:22]);
    match_field("phase_number", 16'(d.phase), 16'(word[40:38]));
    match_field("tdata padding", 16'd0, 16'(word[47:41]));
  endfunction
endclass

module adaptive_hopping_slot_scheduler_tb;

  // Watchdog: cycles without any handshake before the run is declared hung.
  // Must stay well above the long receiver hold-off.
  localparam int STALL_LIMIT  = 6000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int TAIL_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 280;
  // Enough uninterrupted slots to pass the sixth phase boundary (slot 1035)
  localparam int WALK_TICKS   = 1040;

  // Register indexes the block does not map; writes must change nothing
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  typedef enum {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [7:0] neighbors_found, [23:8] coin_random,
                           // [27:24] channel_pick, [31:28] zero
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [0] transmit, [5:1] radio_channel, [21:6] tx_probability,
                           // [37:22] slot_number, [40:38] phase_number, [47:41] zero
  logic [0:0]  out_tuser;  // [0] slot_active
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  slot_plan_board board;

  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_cycles_req;
  int         sent_count;
  logic [7:0] cur_target;

  adaptive_hopping_slot_scheduler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample all three channels at the edge. Results are checked before the
  // request of the same edge is noted: a result can never belong to a
  // request accepted in the same cycle.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_tvalid && out_tready) board.check_decision(out_tuser, out_tdata);
      if (in_tvalid && in_tready)
        board.note_request(ahss_pkg::op_t'(in_tuser), in_tdata[7:0], in_tdata[23:8],
                           in_tdata[27:24]);
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
    end
  end

  // Result receiver: random stalls per the current pacing, plus one long
  // hold-off on request, counted here so the sender keeps pushing meanwhile.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles_req) @(posedge clk);
        hold_cycles_req = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Hang detector: any accepted request, result or register write resets it
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[adaptive_hopping_slot_scheduler] ERROR");
    $finish;
  end

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FULL:           begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SENDER_IDLE:    begin send_idle_pct = 76; recv_stall_pct = 0;  end
      PACE_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default:             begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  // Offer one request, after a random gap, and hold it until accepted.
  // Leave tvalid high on return so back-to-back requests need no toggle.
  task automatic send_req(input ahss_pkg::op_t op, input logic [7:0] found,
                          input logic [15:0] coin, input logic [3:0] pick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, pick, coin, found};
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Discovery tick with the neighbor count below target (any count at target zero), random content
  task automatic send_live_tick();
    logic [7:0] found;
    found = (cur_target == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(cur_target - 1));
    send_req(ahss_pkg::OP_TICK, found, 16'($urandom), 4'($urandom_range(15)));
  endtask

  // Any op code with any content, including unused op three and ticks at or
  // above the target that drop discovery back to idle
  task automatic send_noise();
    send_req(ahss_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)), 16'($urandom),
             4'($urandom_range(15)));
  endtask

  // Lower tvalid and wait until every planned result has been accepted
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Leave cfg_valid high on return; the caller lowers it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [7:0] chan_val, input logic [7:0] tgt_val);
    write_reg(ahss_pkg::CFG_CHAN_COUNT, chan_val);
    write_reg(ahss_pkg::CFG_TARGET, tgt_val);
    cfg_valid  <= 1'b0;
    cur_target = tgt_val;
  endtask

  initial begin : stimulus
    int         blk;
    int         len;
    int         i;
    int         random_start;
    bit         tidy;
    logic [7:0] chan_val;
    logic [7:0] tgt_val;

    board           = new();
    hold_cycles_req = 0;
    sent_count      = 0;
    cur_target      = ahss_pkg::TARGET_RST;
    set_pace(PACE_FULL);

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ahss_pkg::OP_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= ahss_pkg::CFG_CHAN_COUNT;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on reset registers (16 channels, target 10).
    // Tick while idle, unused op and stop while idle: all give the idle result.
    send_req(ahss_pkg::OP_TICK, 8'd0, 16'd0, 4'd0);
    send_req(ahss_pkg::OP_NONE, 8'hFF, 16'hFFFF, 4'hF);
    send_req(ahss_pkg::OP_STOP, 8'hAA, 16'h5555, 4'hA);
    send_req(ahss_pkg::OP_START, 8'h55, 16'hAAAA, 4'h5);
    // Coin zero transmits, coin all-ones listens; top channel on the third,
    // which is also the first phase boundary
    send_req(ahss_pkg::OP_TICK, 8'd0, 16'd0, 4'd0);
    send_req(ahss_pkg::OP_TICK, 8'd9, 16'hFFFF, 4'hF);
    send_req(ahss_pkg::OP_TICK, 8'd5, 16'h7FFF, 4'hF);
    // Run on to the second phase boundary at slot 11
    for (i = 0; i < 8; i++)
      send_req(ahss_pkg::OP_TICK, 8'($urandom_range(9)), 16'($urandom),
               4'($urandom_range(15)));
    // Unused op and stop mid-run keep the counters; a tick while stopped clears
    send_req(ahss_pkg::OP_NONE, 8'd0, 16'd0, 4'd0);
    send_req(ahss_pkg::OP_STOP, 8'd0, 16'd0, 4'd0);
    send_req(ahss_pkg::OP_TICK, 8'd0, 16'd0, 4'd0);
    // Target reached (equal, then far above) ends discovery
    send_req(ahss_pkg::OP_START, 8'd0, 16'd0, 4'd0);
    send_req(ahss_pkg::OP_TICK, 8'd1, 16'd0, 4'd3);
    send_req(ahss_pkg::OP_TICK, 8'd10, 16'd0, 4'd3);
    send_req(ahss_pkg::OP_START, 8'd0, 16'd0, 4'd0);
    send_req(ahss_pkg::OP_TICK, 8'd255, 16'd0, 4'd0);

    // Random part in blocks: drain, reprogram, switch pacing, then mostly
    // well-formed discovery runs with some noise mixed in
    random_start = sent_count;
    blk          = 0;
    while (sent_count - random_start < RANDOM_ITEMS) begin
      drain();
      case (blk)
        0: begin chan_val = 8'd1;   tgt_val = 8'd1;   end
        1: begin chan_val = 8'd0;   tgt_val = 8'd255; end
        2: begin chan_val = 8'd31;  tgt_val = 8'd40;  end
        3: begin chan_val = 8'hE5;  tgt_val = 8'd3;   end
        4: begin chan_val = 8'd17;  tgt_val = 8'd200; end
        5: begin chan_val = 8'd16;  tgt_val = 8'd0;   end
        6: begin chan_val = 8'd8;   tgt_val = 8'd25;  end
        default: begin
          chan_val = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(1, 16));
          tgt_val  = 8'($urandom_range(1, 255));
        end
      endcase
      if (blk == 0) begin
        write_reg(CFG_SPARE_LO, 8'($urandom_range(255)));
        write_reg(CFG_SPARE_HI, 8'($urandom_range(255)));
      end
      configure(chan_val, tgt_val);
      set_pace(pace_t'(blk % 4));
      // Hold the receiver off long enough for the block to fill and stall
      if (blk == 2) hold_cycles_req = HOLD_CYCLES;

      len  = $urandom_range(25, 75);
      tidy = ($urandom_range(99) < 85);
      if (tidy)
        send_req(ahss_pkg::OP_START, 8'($urandom_range(255)), 16'($urandom),
                 4'($urandom_range(15)));
      for (i = 0; i < len; i++) begin
        if (!tidy || $urandom_range(99) < 8) send_noise();
        else send_live_tick();
      end
      blk++;
    end

    // One long uninterrupted discovery run to walk every phase up to 6
    drain();
    configure(8'd7, 8'd255);
    set_pace(PACE_FULL);
    send_req(ahss_pkg::OP_START, 8'd0, 16'd0, 4'd0);
    repeat (WALK_TICKS) send_live_tick();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d discovery slots (%0d transmit), %0d idle resets.",
             board.requests, board.slots, board.transmits, board.idle_resets);
    $display("Highest phase reached %0d; %0d register writes over %0d pacing blocks.",
             board.top_phase, board.reg_writes, blk);
    if (board.mismatches == 0)
      $display("[adaptive_hopping_slot_scheduler] OK");
    else
      $display("[adaptive_hopping_slot_scheduler] ERROR");
    $finish;
  end

endmodule
